// ===== rtl/rbst_pkg.sv =====
// ----------------------------------------------------------------------------
// rbst_pkg: shared types and constants
// Fixed-point format, beat structs and divider widths for the slab test core.
// ----------------------------------------------------------------------------
`default_nettype none
package rbst_pkg;

	localparam int FRAC_BITS = 16;
	localparam int VAL_W     = 32;
	// |bound - origin| needs VAL_W+1 bits, then scaled by 2^FRAC_BITS
	localparam int NUM_W     = VAL_W + 1 + FRAC_BITS;

	localparam logic signed [VAL_W-1:0] T_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] T_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] Z_LO  = '0;
	localparam logic signed [VAL_W-1:0] Z_HI  = VAL_W'(1) << FRAC_BITS;

	typedef struct packed {
		logic signed [VAL_W-1:0] origin_x;
		logic signed [VAL_W-1:0] origin_y;
		logic signed [VAL_W-1:0] origin_z;
		logic signed [VAL_W-1:0] dir_x;
		logic signed [VAL_W-1:0] dir_y;
		logic signed [VAL_W-1:0] dir_z;
		logic signed [VAL_W-1:0] box_min_x;
		logic signed [VAL_W-1:0] box_min_y;
		logic signed [VAL_W-1:0] box_max_x;
		logic signed [VAL_W-1:0] box_max_y;
		logic signed [VAL_W-1:0] best_dist;
	} req_t;

	typedef struct packed {
		logic                    hit;
		logic signed [VAL_W-1:0] entry_dist;
	} rsp_t;

endpackage
`default_nettype wire

// ===== rtl/rbst_div.sv =====
// ----------------------------------------------------------------------------
// rbst_div: pipelined unsigned divider
// Restoring division, one quotient bit per stage, NUM_W stages, one beat/cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rbst_div
	import rbst_pkg::*;
(
	input  wire logic             clk,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [VAL_W-1:0] den,
	output logic      [NUM_W-1:0] quo
);

	// remainder stays below den, so VAL_W bits hold it
	logic [VAL_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] nq_s  [NUM_W];
	logic [VAL_W-1:0] den_s [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic [VAL_W-1:0] rem_in;
		logic [NUM_W-1:0] nq_in;
		logic [VAL_W-1:0] den_in;
		logic [VAL_W:0]   trial;
		logic             fits;
		if (k == 0) begin : g_head
			assign rem_in = '0;
			assign nq_in  = num;
			assign den_in = den;
		end else begin : g_link
			assign rem_in = rem_s[k-1];
			assign nq_in  = nq_s[k-1];
			assign den_in = den_s[k-1];
		end
		assign trial = {rem_in, nq_in[NUM_W-1]};
		assign fits  = trial >= {1'b0, den_in};
		always_ff @(posedge clk) begin
			rem_s[k] <= fits ? VAL_W'(trial - {1'b0, den_in}) : trial[VAL_W-1:0];
			nq_s[k]  <= {nq_in[NUM_W-2:0], fits};
			den_s[k] <= den_in;
		end
	end

	assign quo = nq_s[NUM_W-1];

endmodule
`default_nettype wire

// ===== rtl/ray_box_slab_test_core.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_test_core: ray versus axis-aligned box, slab method
// Fully pipelined query engine, one query per clock, fixed latency.
// ----------------------------------------------------------------------------
// A query beat is taken whenever start is high; busy is always low, so a new
// beat may enter every cycle. Each query produces one result beat, flagged by
// done for one cycle; distances are in Q16.16. The result path runs through the
// input register, the six parallel restoring dividers, one quotient bit per
// stage, then the order and slab-update registers.
// The receiver cannot stall, so nothing holds the pipe and results leave in
// order.
`default_nettype none
module ray_box_slab_test_core
	import rbst_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t req,
	output logic      done,
	output rsp_t      rsp
);

	typedef logic signed [VAL_W-1:0] val_t;

	// sideband that rides alongside the dividers
	typedef struct packed {
		logic       valid;
		logic [5:0] neg;    // quotient sign per lane (lo/hi per axis)
		logic [2:0] par;    // axis direction is zero
		logic [2:0] pfail;  // parallel axis origin outside slab
		val_t       best;
	} side_t;

	typedef struct packed {
		val_t tn;
		val_t tf;
		logic fail;
	} acc_t;

	assign busy = 1'b0;

	// ---------------- stage 1: numerators and divisor magnitudes ----------
	val_t org  [3];
	val_t dirv [3];
	val_t lo   [3];
	val_t hi   [3];

	always_comb begin
		org[0] = req.origin_x;  org[1] = req.origin_y;  org[2] = req.origin_z;
		dirv[0] = req.dir_x;    dirv[1] = req.dir_y;    dirv[2] = req.dir_z;
		lo[0] = req.box_min_x;  lo[1] = req.box_min_y;  lo[2] = Z_LO;
		hi[0] = req.box_max_x;  hi[1] = req.box_max_y;  hi[2] = Z_HI;
	end

	logic [NUM_W-1:0] num_s1 [6];
	logic [VAL_W-1:0] den_s1 [6];
	side_t            side_s1;
	logic [5:0]       neg_c;
	logic [2:0]       par_c;
	logic [2:0]       pfail_c;

	for (genvar a = 0; a < 3; a++) begin : g_prep
		logic signed [VAL_W:0] dlo, dhi;
		logic        [VAL_W:0] mlo, mhi;
		logic        [VAL_W-1:0] dmag;
		assign dlo  = {lo[a][VAL_W-1], lo[a]} - {org[a][VAL_W-1], org[a]};
		assign dhi  = {hi[a][VAL_W-1], hi[a]} - {org[a][VAL_W-1], org[a]};
		assign mlo  = dlo[VAL_W] ? (VAL_W+1)'(-dlo) : dlo;
		assign mhi  = dhi[VAL_W] ? (VAL_W+1)'(-dhi) : dhi;
		assign dmag = dirv[a][VAL_W-1] ? VAL_W'(-dirv[a]) : dirv[a];
		assign neg_c[2*a]   = dlo[VAL_W] ^ dirv[a][VAL_W-1];
		assign neg_c[2*a+1] = dhi[VAL_W] ^ dirv[a][VAL_W-1];
		assign par_c[a]     = (dirv[a] == '0);
		assign pfail_c[a]   = (org[a] < lo[a]) || (org[a] > hi[a]);
		always_ff @(posedge clk) begin
			num_s1[2*a]     <= {mlo, {FRAC_BITS{1'b0}}};
			num_s1[2*a+1]   <= {mhi, {FRAC_BITS{1'b0}}};
			den_s1[2*a]     <= dmag;
			den_s1[2*a+1]   <= dmag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else begin
			side_s1.valid <= start;
			side_s1.neg   <= neg_c;
			side_s1.par   <= par_c;
			side_s1.pfail <= pfail_c;
			side_s1.best  <= req.best_dist;
		end
	end

	// ---------------- divider lanes and matching sideband delay -----------
	logic [NUM_W-1:0] quo [6];

	for (genvar l = 0; l < 6; l++) begin : g_div
		rbst_div u_div (
			.clk (clk),
			.num (num_s1[l]),
			.den (den_s1[l]),
			.quo (quo[l])
		);
	end

	// one sideband register per divider stage
	side_t side_d [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_side
		side_t side_in;
		if (k == 0) begin : g_head
			assign side_in = side_s1;
		end else begin : g_link
			assign side_in = side_d[k-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_d[k] <= '0;
			end else begin
				side_d[k] <= side_in;
			end
		end
	end

	side_t sd;
	assign sd = side_d[NUM_W-1];

	// ---------------- stage 2: sign, saturate, order ----------------------
	localparam logic [NUM_W-1:0] MAG_LIM = NUM_W'(1) << (VAL_W-1);

	function automatic val_t sat_q(input logic [NUM_W-1:0] mag, input logic neg);
		val_t r;
		if (neg) begin
			r = (mag > MAG_LIM) ? T_MIN : VAL_W'(-mag);
		end else begin
			r = (mag >= MAG_LIM) ? T_MAX : VAL_W'(mag);
		end
		return r;
	endfunction

	val_t  t1_s2 [3];
	val_t  t2_s2 [3];
	side_t side_s2;

	for (genvar a = 0; a < 3; a++) begin : g_ord
		val_t qa, qb;
		assign qa = sat_q(quo[2*a],   sd.neg[2*a]);
		assign qb = sat_q(quo[2*a+1], sd.neg[2*a+1]);
		always_ff @(posedge clk) begin
			t1_s2[a] <= (qa > qb) ? qb : qa;
			t2_s2[a] <= (qa > qb) ? qa : qb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
		end else begin
			side_s2 <= sd;
		end
	end

	// one axis of the slab update; once failed, later values do not matter
	function automatic acc_t axis_step(input acc_t in_acc, input logic par,
		input logic pfail, input val_t t1, input val_t t2, input val_t best);
		acc_t r;
		r = in_acc;
		if (par) begin
			r.fail = r.fail | pfail;
		end else begin
			if (t1 > r.tn) r.tn = t1;
			if (r.tn > best) r.fail = 1'b1;
			if (t2 < r.tf) r.tf = t2;
			if ((r.tn > r.tf) || r.tf[VAL_W-1]) r.fail = 1'b1;
		end
		return r;
	endfunction

	// ---------------- stage 3: z then y axes ------------------------------
	acc_t  acc_s3;
	val_t  t1x_s3, t2x_s3;
	side_t side_s3;
	acc_t  acc_z, acc_zy, acc_init;

	always_comb begin
		acc_init.tn   = T_MIN;
		acc_init.tf   = T_MAX;
		acc_init.fail = 1'b0;
		acc_z  = axis_step(acc_init, side_s2.par[2], side_s2.pfail[2],
			t1_s2[2], t2_s2[2], side_s2.best);
		acc_zy = axis_step(acc_z, side_s2.par[1], side_s2.pfail[1],
			t1_s2[1], t2_s2[1], side_s2.best);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3 <= '0;
		end else begin
			side_s3 <= side_s2;
		end
	end

	always_ff @(posedge clk) begin
		acc_s3        <= acc_zy;
		t1x_s3        <= t1_s2[0];
		t2x_s3        <= t2_s2[0];
	end

	// ---------------- stage 4: x axis and result register -----------------
	acc_t acc_x;

	always_comb begin
		acc_x = axis_step(acc_s3, side_s3.par[0], side_s3.pfail[0],
			t1x_s3, t2x_s3, side_s3.best);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= side_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		rsp.hit        <= !acc_x.fail;
		rsp.entry_dist <= acc_x.fail ? side_s3.best : acc_x.tn;
	end

endmodule
`default_nettype wire

// ===== bench/ray_box_slab_test_core_test.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_test_core_test: self-checking bench for the slab test core
// Drives directed and random ray/box queries, predicts each hit and entry
// distance in fixed point, and checks every result beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ray_box_slab_test_core_test;
	import rbst_pkg::*;

	localparam int LATENCY   = NUM_W + 4;
	localparam int N_RANDOM  = 930;
	localparam int CYC_LIMIT = 200000;
	localparam int ONE       = 1 << FRAC_BITS;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;

	ray_box_slab_test_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	req_t query_q[$];      // queries waiting to be driven
	rsp_t expected_q[$];   // predicted results, oldest first
	int   mismatches;
	int   cycles;
	int   gap_pct;         // sender idle chance in percent
	bit   feeding_done;

	// Append a query to the end of the pending queue.
	function automatic void add_query(req_t q);
		query_q.insert(query_q.size(), q);
	endfunction

	// Clamp a 64-bit signed value into the 32-bit range.
	function automatic logic signed [31:0] clamp32(longint v);
		if (v > longint'(T_MAX))
			return T_MAX;
		if (v < longint'(T_MIN))
			return T_MIN;
		return v[31:0];
	endfunction

	// Distance to a slab plane: (bound - origin) << FRAC_BITS / dir, truncated.
	function automatic logic signed [31:0] plane_dist(longint bound, longint org,
			longint dir);
		longint num;
		num = (bound - org) * (longint'(1) << FRAC_BITS);
		return clamp32(num / dir);
	endfunction

	// Slab test predictor: visits z, y, x and stops at the first miss.
	function automatic rsp_t predict_slab(req_t q);
		longint org[3], dir[3], lo[3], hi[3];
		longint best, tnear, tfar, t1, t2, tmp;
		bit     hit;
		rsp_t   r;
		org[0] = q.origin_x;  org[1] = q.origin_y;  org[2] = q.origin_z;
		dir[0] = q.dir_x;     dir[1] = q.dir_y;     dir[2] = q.dir_z;
		lo[0]  = q.box_min_x; lo[1]  = q.box_min_y; lo[2]  = longint'(Z_LO);
		hi[0]  = q.box_max_x; hi[1]  = q.box_max_y; hi[2]  = longint'(Z_HI);
		best  = q.best_dist;
		tnear = longint'(T_MIN);
		tfar  = longint'(T_MAX);
		hit   = 1'b1;
		for (int ax = 2; ax >= 0 && hit; ax--) begin
			if (dir[ax] == 0) begin
				// parallel: origin must sit between the planes
				if (org[ax] < lo[ax] || org[ax] > hi[ax])
					hit = 1'b0;
			end else begin
				t1 = plane_dist(lo[ax], org[ax], dir[ax]);
				t2 = plane_dist(hi[ax], org[ax], dir[ax]);
				if (t1 > t2) begin
					tmp = t1; t1 = t2; t2 = tmp;
				end
				if (t1 > tnear) begin
					tnear = t1;
					if (tnear > best) begin
						hit = 1'b0;
						break;
					end
				end
				if (t2 < tfar)
					tfar = t2;
				if (tnear > tfar || tfar < 0)
					hit = 1'b0;
			end
		end
		r.hit = hit;
		r.entry_dist = hit ? tnear[31:0] : best[31:0];
		return r;
	endfunction

	// Random 32-bit value biased toward small numbers, extremes and zero.
	function automatic logic [31:0] rand_val();
		case ($urandom_range(9))
			0:       return 32'h0;
			1:       return T_MAX;
			2:       return T_MIN;
			3:       return $urandom;
			4:       return $urandom_range(1, 4) << FRAC_BITS;
			default: return 32'($signed($urandom_range(0, 20 << FRAC_BITS))
				- (10 << FRAC_BITS));
		endcase
	endfunction

	// Random query: mostly rand_val fields, boxes usually ordered; some are pure noise.
	function automatic req_t rand_query();
		req_t q;
		logic signed [31:0] a, b;
		if ($urandom_range(9) < 2) begin
			// noise: every field uniform over the whole range
			q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom};
			return q;
		end
		q.origin_x = rand_val(); q.origin_y = rand_val(); q.origin_z = rand_val();
		q.dir_x = ($urandom_range(5) == 0) ? 32'h0 : rand_val();
		q.dir_y = ($urandom_range(5) == 0) ? 32'h0 : rand_val();
		q.dir_z = ($urandom_range(5) == 0) ? 32'h0 : rand_val();
		a = rand_val(); b = rand_val();
		if ($urandom_range(7) != 0 && a > b) begin
			q.box_min_x = b; q.box_max_x = a;
		end else begin
			q.box_min_x = a; q.box_max_x = b;
		end
		a = rand_val(); b = rand_val();
		if ($urandom_range(7) != 0 && a > b) begin
			q.box_min_y = b; q.box_max_y = a;
		end else begin
			q.box_min_y = a; q.box_max_y = b;
		end
		q.best_dist = ($urandom_range(3) == 0) ? T_MAX : rand_val();
		return q;
	endfunction

	// Directed query builder.
	function automatic req_t mk(int ox, int oy, int oz, int dx, int dy, int dz,
			int minx, int miny, int maxx, int maxy, int best);
		req_t q;
		q.origin_x = ox;    q.origin_y = oy;    q.origin_z = oz;
		q.dir_x = dx;       q.dir_y = dy;       q.dir_z = dz;
		q.box_min_x = minx; q.box_min_y = miny;
		q.box_max_x = maxx; q.box_max_y = maxy;
		q.best_dist = best;
		return q;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stimulus: directed cases, then three random phases with different idle rates.
	initial begin
		req_t q;
		arst_n = 1'b0;
		feeding_done = 1'b0;
		gap_pct = 26;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// plain hit along x through a unit box
		add_query(mk(-ONE, ONE/2, ONE/2, ONE, 0, 0, 0, 0, ONE, ONE, T_MAX));
		// same ray, but best distance nearer than the entry
		add_query(mk(-ONE, ONE/2, ONE/2, ONE, 0, 0, 0, 0, ONE, ONE, ONE/2));
		// entry equal to best distance still hits
		add_query(mk(-ONE, ONE/2, ONE/2, ONE, 0, 0, 0, 0, ONE, ONE, ONE));
		// all directions zero, origin inside: tNear stays at most negative
		add_query(mk(ONE/2, ONE/2, ONE/2, 0, 0, 0, 0, 0, ONE, ONE, 0));
		// parallel z with origin outside the z slab
		add_query(mk(0, 0, 2*ONE, ONE, ONE, 0, -ONE, -ONE, ONE, ONE, T_MAX));
		// parallel on inverted x box always misses
		add_query(mk(0, 0, ONE/2, 0, ONE, ONE, ONE, -ONE, -ONE, ONE, T_MAX));
		// inverted box on a moving axis is reordered
		add_query(mk(-ONE, 0, ONE/2, ONE, 0, 0, ONE, -ONE, 0, ONE, T_MAX));
		// box behind the ray: tFar negative
		add_query(mk(5*ONE, 0, ONE/2, ONE, 0, 0, 0, -ONE, ONE, ONE, T_MAX));
		// tNear just equals tFar: touching a corner
		add_query(mk(-ONE, -ONE, ONE/2, ONE, ONE, 0, 0, 0, 0, 0, T_MAX));
		// x and y slabs only touch along the ray, at a box corner
		add_query(mk(-ONE, 3*ONE, ONE/2, ONE, -ONE, 0, 0, 0, ONE, ONE, T_MAX));
		// negative directions on all axes
		add_query(mk(3*ONE, 3*ONE, 3*ONE, -ONE, -ONE, -ONE, 0, 0, ONE, ONE,
			T_MAX));
		// quotient saturation: tiny direction, huge span
		add_query(mk(T_MIN, 0, ONE/2, 1, 0, 0, T_MIN, -ONE, T_MAX, ONE, T_MAX));
		add_query(mk(T_MAX, T_MIN, ONE/2, -1, 1, 0, T_MIN, T_MIN, T_MAX, T_MAX,
			T_MAX));
		// extreme directions and origins
		add_query(mk(T_MIN, T_MAX, T_MIN, T_MAX, T_MIN, T_MAX, T_MIN, T_MIN,
			T_MAX, T_MAX, T_MIN));
		add_query(mk(T_MAX, T_MIN, T_MAX, T_MIN, T_MAX, T_MIN, T_MAX, T_MAX,
			T_MIN, T_MIN, T_MAX));
		// all ones / all zeros fields
		add_query(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
		add_query(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// negative best distance
		add_query(mk(ONE/2, ONE/2, ONE/2, 0, 0, 0, 0, 0, ONE, ONE, T_MIN));
		// early miss on z before y and x are looked at
		add_query(mk(0, 0, -4*ONE, ONE, ONE, ONE, 0, 0, ONE, ONE, ONE));

		for (int phase = 0; phase < 3; phase++) begin
			gap_pct = (phase == 0) ? 26 : (phase == 1) ? 87 : 0;
			for (int i = 0; i < N_RANDOM / 3; i++) begin
				q = rand_query();
				add_query(q);
			end
			// let this phase drain before changing the pacing
			wait (query_q.size() == 0);
		end
		feeding_done = 1'b1;
	end

	// Driver: offers a beat from the queue, idling at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req   <= '0;
		end else begin
			if (start && !busy)
				expected_q.insert(expected_q.size(), predict_slab(req));
			if (start && busy) begin
				// hold the current beat until taken
			end else if (query_q.size() > 0 && $urandom_range(99) >= gap_pct) begin
				start <= 1'b1;
				req   <= query_q.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: checks every result beat against the oldest prediction.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: hit=%0b entry=%0d",
						rsp.hit, rsp.entry_dist);
			end else begin
				want = expected_q.pop_front();
				if (rsp.hit !== want.hit || rsp.entry_dist !== want.entry_dist) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected hit=%0b entry=%0d, got hit=%0b entry=%0d",
							want.hit, want.entry_dist, rsp.hit, rsp.entry_dist);
				end
			end
		end
	end

	// Watchdog, plus end of run once everything has drained.
	initial begin
		mismatches = 0;
		cycles = 0;
		fork
			forever begin
				@(posedge clk);
				cycles++;
				if (cycles > CYC_LIMIT) begin
					$display("TB_ERROR");
					$finish;
				end
			end
			begin
				wait (feeding_done);
				@(posedge clk);
				while (start || expected_q.size() > 0)
					@(posedge clk);
				repeat (LATENCY + 10) @(posedge clk);
				if (mismatches == 0 && expected_q.size() == 0)
					$display("TB_OK");
				else
					$display("TB_ERROR");
				$finish;
			end
		join
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/rbst_pkg.sv
rtl/rbst_div.sv
rtl/ray_box_slab_test_core.sv
bench/ray_box_slab_test_core_test.sv
